[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, sampled on clock and off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SWN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/swn_pkg.sv]
// ----------------------------------------------------------------------------
// swn_pkg
// shared widths, register codes and beat types of the skin weight normalizer
// ----------------------------------------------------------------------------
package swn_pkg;

   localparam int FIELD_SLOTS = 4;
   localparam int BONE_W      = 8;
   localparam int DIST_W      = 32;
   localparam int WEIGHT_W    = 16;
   localparam int QUO_W       = 16;
   localparam int RAW_W       = 16;
   localparam int SUM_W       = 18;
   localparam int MAXD_W      = 16;
   localparam int USE_W       = 3;
   localparam int CNT_W       = 3;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 3;

   localparam logic [WEIGHT_W-1:0] ONE_Q15    = 16'd32768;
   localparam logic [RAW_W-1:0]    FLOOR_Q15  = 16'd33;
   localparam logic [MAXD_W-1:0]   MAXD_RESET = 16'd256;
   localparam logic [USE_W-1:0]    USE_RESET  = 3'd4;
   localparam logic [DIST_W-1:0]   RSQ_RESET  = DIST_W'(MAXD_RESET) * DIST_W'(MAXD_RESET);

   typedef enum logic {
      REG_MAX_DISTANCE = 1'b0,
      REG_SLOTS_IN_USE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [DIST_W-1:0] rsq;
      logic [USE_W-1:0]  slots;
   } cfg_type;

   typedef struct packed {
      logic [FIELD_SLOTS-1:0]             valid;
      logic [FIELD_SLOTS-1:0][BONE_W-1:0] bone;
   } side1_type;

   typedef struct packed {
      logic [FIELD_SLOTS-1:0]             valid;
      logic [FIELD_SLOTS-1:0][BONE_W-1:0] bone;
      logic [FIELD_SLOTS-1:0][RAW_W-1:0]  raw;
      logic [CNT_W-1:0]                   count;
   } side2_type;

   typedef struct packed {
      logic [FIELD_SLOTS-1:0][BONE_W-1:0]   bone;
      logic [FIELD_SLOTS-1:0][WEIGHT_W-1:0] weight;
   } result_type;

endpackage

[sv/swn_csr.sv]
// ----------------------------------------------------------------------------
// swn_csr
// configuration registers behind the apb port, radius squared kept alongside
// ----------------------------------------------------------------------------
module swn_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [swn_pkg::ADDR_W-1:0]  paddr,
   input  logic [swn_pkg::DATA_W-1:0]  pwdata,
   output logic [swn_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output swn_pkg::cfg_type            cfg
);
   import swn_pkg::*;

   logic [MAXD_W-1:0] maxd_ff;
   logic [USE_W-1:0]  slots_ff;
   logic [DIST_W-1:0] rsq_ff;
   logic [DIST_W-1:0] rsq_in;
   logic              wr;
   reg_index_type     idx;

   assign idx    = reg_index_type'(paddr[2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   // square at the write so the radius and its square change on the same edge
   assign rsq_in = DIST_W'(pwdata[MAXD_W-1:0]) * DIST_W'(pwdata[MAXD_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         maxd_ff  <= MAXD_RESET;
         slots_ff <= USE_RESET;
         rsq_ff   <= RSQ_RESET;
      end else if (wr) begin
         unique case (idx)
            REG_MAX_DISTANCE: begin
               maxd_ff <= pwdata[MAXD_W-1:0];
               rsq_ff  <= rsq_in;
            end
            REG_SLOTS_IN_USE: begin
               slots_ff <= pwdata[USE_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MAX_DISTANCE: prdata = DATA_W'(maxd_ff);
         REG_SLOTS_IN_USE: prdata = DATA_W'(slots_ff);
      endcase
   end

   assign cfg.rsq   = rsq_ff;
   assign cfg.slots = slots_ff;

endmodule

[sv/swn_div_pipe.sv]
// ----------------------------------------------------------------------------
// swn_div_pipe
// restoring divider, one quotient bit per register stage, lanes side by side
// ----------------------------------------------------------------------------
module swn_div_pipe #(
   parameter int LANES  = 4,
   parameter int DEN_W  = 32,
   parameter int QUO_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [LANES-1:0][DEN_W-1:0]      in_rem,
   input  logic [LANES-1:0][DEN_W-1:0]      in_den,
   input  logic [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   output logic [LANES-1:0][QUO_W-1:0]      out_quo,
   output logic [SIDE_W-1:0]                out_side
);
   import swn_pkg::*;

   logic [QUO_W-1:0]                         valid_ff;
   logic [QUO_W-1:0]                         valid_src;
   logic [QUO_W-1:0][SIDE_W-1:0]             side_ff;
   logic [QUO_W-1:0][SIDE_W-1:0]             side_src;
   logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]   rem_ff;
   logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]   rem_in;
   logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]   den_ff;
   logic [QUO_W-1:0][LANES-1:0][DEN_W-1:0]   den_src;
   logic [QUO_W-1:0][LANES-1:0][QUO_W-1:0]   quo_ff;
   logic [QUO_W-1:0][LANES-1:0][QUO_W-1:0]   quo_in;
   logic [QUO_W-1:0][LANES-1:0][QUO_W-1:0]   quo_src;
   logic [QUO_W-1:0][LANES-1:0][DEN_W:0]     cand;
   logic [QUO_W-1:0][LANES-1:0][DEN_W+1:0]   diff;

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign valid_src[s] = in_valid;
         assign side_src[s]  = in_side;
      end else begin : g_next
         assign valid_src[s] = valid_ff[s-1];
         assign side_src[s]  = side_ff[s-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         if (s == 0) begin : g_first
            // first step has no shift: the entry remainder may equal the divisor
            assign cand[s][l]    = {1'b0, in_rem[l]};
            assign den_src[s][l] = in_den[l];
            assign quo_src[s][l] = '0;
         end else begin : g_next
            assign cand[s][l]    = {rem_ff[s-1][l], 1'b0};
            assign den_src[s][l] = den_ff[s-1][l];
            assign quo_src[s][l] = quo_ff[s-1][l];
         end

         always_comb begin
            diff[s][l]   = {1'b0, cand[s][l]} - {2'b00, den_src[s][l]};
            rem_in[s][l] = diff[s][l][DEN_W+1] ? cand[s][l][DEN_W-1:0]
                                               : diff[s][l][DEN_W-1:0];
            quo_in[s][l] = quo_src[s][l];
            quo_in[s][l][QUO_W-1-s] = ~diff[s][l][DEN_W+1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_src[s];
            quo_ff[s]  <= quo_in[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

[sv/swn_out_buf.sv]
// ----------------------------------------------------------------------------
// swn_out_buf
// output register plus skid entry; the pipeline advances while the skid is free
// ----------------------------------------------------------------------------
module swn_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fin_valid,
   input  swn_pkg::result_type  fin_data,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output swn_pkg::result_type  rsp_data
);
   import swn_pkg::*;

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type out_ff;
   result_type out_in;
   result_type skid_ff;
   result_type skid_in;
   logic       take;
   logic       arrive;

   assign advance = ~skid_valid_ff;
   assign take    = out_valid_ff & rsp_ready;
   assign arrive  = fin_valid & ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!out_valid_ff || take) begin
            out_in       = fin_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = fin_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[sv/skin_weight_normalizer.sv]
// ----------------------------------------------------------------------------
// skin_weight_normalizer
// bone indices and normalized blend weights for a vertex with four bone slots
// ----------------------------------------------------------------------------
//  channel   prefix  handshake              beat
//  input     req_    req_valid/req_ready    four slots: valid, bone, dist_sq
//  result    rsp_    rsp_valid/rsp_ready    four slots: out_bone, weight
//  config    csr_    psel/penable/pready    max_distance, slots_in_use
//
//  one vertex per cycle while the skid entry is free; each beat passes the input
//  stage, 16-stage raw weight divider, sum stage, 16-stage normalizing divider
//  and output register in that order
//  reset: synchronous, clears the valid bits and restores the registers
//  a stalled result moves into a skid entry; req_ready drops only while it is full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skin_weight_normalizer #(
   parameter int SLOTS = 4
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_valid_0,
   input  logic [swn_pkg::BONE_W-1:0]    req_bone_0,
   input  logic [swn_pkg::DIST_W-1:0]    req_dist_sq_0,
   input  logic                          req_valid_1,
   input  logic [swn_pkg::BONE_W-1:0]    req_bone_1,
   input  logic [swn_pkg::DIST_W-1:0]    req_dist_sq_1,
   input  logic                          req_valid_2,
   input  logic [swn_pkg::BONE_W-1:0]    req_bone_2,
   input  logic [swn_pkg::DIST_W-1:0]    req_dist_sq_2,
   input  logic                          req_valid_3,
   input  logic [swn_pkg::BONE_W-1:0]    req_bone_3,
   input  logic [swn_pkg::DIST_W-1:0]    req_dist_sq_3,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swn_pkg::BONE_W-1:0]    rsp_out_bone_0,
   output logic [swn_pkg::WEIGHT_W-1:0]  rsp_weight_0,
   output logic [swn_pkg::BONE_W-1:0]    rsp_out_bone_1,
   output logic [swn_pkg::WEIGHT_W-1:0]  rsp_weight_1,
   output logic [swn_pkg::BONE_W-1:0]    rsp_out_bone_2,
   output logic [swn_pkg::WEIGHT_W-1:0]  rsp_weight_2,
   output logic [swn_pkg::BONE_W-1:0]    rsp_out_bone_3,
   output logic [swn_pkg::WEIGHT_W-1:0]  rsp_weight_3,

   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [swn_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [swn_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [swn_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import swn_pkg::*;

   // slots past the field count never carry data, so no divider lane for them
   localparam int LANES = (SLOTS < FIELD_SLOTS) ? SLOTS : FIELD_SLOTS;

   cfg_type                            cfg;
   logic                               advance;
   logic [USE_W-1:0]                   use_cnt;

   logic [FIELD_SLOTS-1:0]             req_v;
   logic [FIELD_SLOTS-1:0][BONE_W-1:0] req_b;
   logic [FIELD_SLOTS-1:0][DIST_W-1:0] req_d;

   logic                               a_valid_ff;
   side1_type                          a_side_ff;
   side1_type                          a_side_in;
   logic [LANES-1:0][DIST_W-1:0]       a_rem_ff;
   logic [LANES-1:0][DIST_W-1:0]       a_rem_in;
   logic [LANES-1:0][DIST_W-1:0]       a_den_ff;
   logic [LANES-1:0][DIST_W-1:0]       a_den_in;

   logic                               d1_valid;
   logic [LANES-1:0][QUO_W-1:0]        d1_quo;
   side1_type                          d1_side;

   logic [FIELD_SLOTS-1:0][RAW_W-1:0]  raw_w;
   logic                               b_valid_ff;
   side2_type                          b_side_ff;
   side2_type                          b_side_in;
   logic [SUM_W-1:0]                   b_sum_ff;
   logic [SUM_W-1:0]                   b_sum_in;

   logic [LANES-1:0][SUM_W-1:0]        d2_rem;
   logic [LANES-1:0][SUM_W-1:0]        d2_den;
   logic                               d2_valid;
   logic [LANES-1:0][QUO_W-1:0]        d2_quo;
   side2_type                          d2_side;

   logic [FIELD_SLOTS-1:0][WEIGHT_W-1:0] fin_weight;
   result_type                         fin_data;
   result_type                         rsp_data;

   swn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   assign req_v = {req_valid_3, req_valid_2, req_valid_1, req_valid_0};
   assign req_b = {req_bone_3, req_bone_2, req_bone_1, req_bone_0};
   assign req_d = {req_dist_sq_3, req_dist_sq_2, req_dist_sq_1, req_dist_sq_0};

   assign req_ready = advance;
   assign use_cnt   = (cfg.slots > USE_W'(LANES)) ? USE_W'(LANES) : cfg.slots;

   // input stage: slot gating and the remainder rsq - d
   for (genvar k = 0; k < FIELD_SLOTS; k++) begin : g_in
      assign a_side_in.valid[k] = req_v[k] & (USE_W'(k) < use_cnt);
      assign a_side_in.bone[k]  = a_side_in.valid[k] ? req_b[k] : '0;
      if (k < LANES) begin : g_lane
         logic in_range;
         // out of range or zero radius gives a zero quotient, later floored
         assign in_range    = a_side_in.valid[k] & (req_d[k] < cfg.rsq);
         assign a_rem_in[k] = in_range ? (cfg.rsq - req_d[k]) : '0;
         assign a_den_in[k] = in_range ? cfg.rsq : DIST_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= a_side_in;
         a_rem_ff  <= a_rem_in;
         a_den_ff  <= a_den_in;
      end
   end

   swn_div_pipe #(
      .LANES  (LANES),
      .DEN_W  (DIST_W),
      .QUO_W  (QUO_W),
      .SIDE_W ($bits(side1_type))
   ) u_raw_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (a_valid_ff),
      .in_rem    (a_rem_ff),
      .in_den    (a_den_ff),
      .in_side   (a_side_ff),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // sum stage: floor the raw weights and add them up
   for (genvar k = 0; k < FIELD_SLOTS; k++) begin : g_raw
      if (k < LANES) begin : g_lane
         assign raw_w[k] = !d1_side.valid[k] ? '0 :
                           (d1_quo[k] <= QUO_W'(FLOOR_Q15)) ? FLOOR_Q15 :
                           d1_quo[k][RAW_W-1:0];
      end else begin : g_none
         assign raw_w[k] = '0;
      end
   end

   always_comb begin
      b_sum_in = '0;
      for (int k = 0; k < FIELD_SLOTS; k++) begin
         b_sum_in = b_sum_in + SUM_W'(raw_w[k]);
      end
      b_side_in.valid = d1_side.valid;
      b_side_in.bone  = d1_side.bone;
      b_side_in.raw   = raw_w;
      b_side_in.count = CNT_W'($countones(d1_side.valid));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_side_ff <= b_side_in;
         b_sum_ff  <= b_sum_in;
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_norm_in
      assign d2_rem[k] = SUM_W'(b_side_ff.raw[k]);
      // empty vertex: divisor kept nonzero, its quotient is not used
      assign d2_den[k] = (b_side_ff.count == '0) ? SUM_W'(1) : b_sum_ff;
   end

   swn_div_pipe #(
      .LANES  (LANES),
      .DEN_W  (SUM_W),
      .QUO_W  (QUO_W),
      .SIDE_W ($bits(side2_type))
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (b_valid_ff),
      .in_rem    (d2_rem),
      .in_den    (d2_den),
      .in_side   (b_side_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   // only the first count positions take the normalized weight
   for (genvar k = 0; k < FIELD_SLOTS; k++) begin : g_fin
      if (k < LANES) begin : g_lane
         always_comb begin
            if (d2_side.count == '0) begin
               fin_weight[k] = (k == 0) ? ONE_Q15 : '0;
            end else if (CNT_W'(k) < d2_side.count) begin
               fin_weight[k] = d2_quo[k];
            end else if (d2_side.valid[k]) begin
               fin_weight[k] = WEIGHT_W'(d2_side.raw[k]);
            end else begin
               fin_weight[k] = '0;
            end
         end
      end else begin : g_none
         assign fin_weight[k] = '0;
      end
   end

   assign fin_data.bone   = d2_side.bone;
   assign fin_data.weight = fin_weight;

   swn_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (d2_valid),
      .fin_data  (fin_data),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_bone_0 = rsp_data.bone[0];
   assign rsp_out_bone_1 = rsp_data.bone[1];
   assign rsp_out_bone_2 = rsp_data.bone[2];
   assign rsp_out_bone_3 = rsp_data.bone[3];
   assign rsp_weight_0   = rsp_data.weight[0];
   assign rsp_weight_1   = rsp_data.weight[1];
   assign rsp_weight_2   = rsp_data.weight[2];
   assign rsp_weight_3   = rsp_data.weight[3];

   // a held input side means the output register and skid both hold beats
   `SWN_ASSERT(a_stall_has_rsp, !req_ready |-> rsp_valid, "input stalled with no result held")
   `SWN_ASSERT_NEXT(a_stall_keeps_rsp, !req_ready, rsp_valid, "skid beat lost after stall")
   `SWN_ASSERT(a_weight_range, rsp_valid |-> (rsp_weight_0 <= ONE_Q15 && rsp_weight_1 <= ONE_Q15 && rsp_weight_2 <= ONE_Q15 && rsp_weight_3 <= ONE_Q15), "weight above one")

endmodule

[sim/tb_skin_weight_normalizer.sv]
// ----------------------------------------------------------------------------
// tb_skin_weight_normalizer
// Self-checking bench for the four-slot blend weight normalizer. A short
// table of vertices (reset settings, extremes, the floor weight, gaps in the
// valid slots, no valid slot) is followed by random vertices under several
// radius and slot-count settings, with sender gaps and receiver stalls.
// Every result beat is compared with the table expectation or a weight predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_skin_weight_normalizer;
   timeunit 1ns;
   timeprecision 1ps;

   import swn_pkg::*;

   localparam int TAB_LEN     = 17;
   localparam int SETTLE_GAP  = 40;
   localparam int TAIL_GAP    = 60;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [FIELD_SLOTS-1:0]             valid;
      logic [FIELD_SLOTS-1:0][BONE_W-1:0] bone;
      logic [FIELD_SLOTS-1:0][DIST_W-1:0] dist_sq;
   } vertex_type;

   typedef struct packed {
      vertex_type vtx;
      bit         typed;
      result_type want;
   } blend_row_type;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   vertex_type drv       = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BONE_W-1:0]   rsp_out_bone_0, rsp_out_bone_1, rsp_out_bone_2, rsp_out_bone_3;
   logic [WEIGHT_W-1:0] rsp_weight_0, rsp_weight_1, rsp_weight_2, rsp_weight_3;

   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0] csr_pwdata  = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // bench copy of the two registers
   logic [MAXD_W-1:0] radius_q8  = MAXD_RESET;
   logic [USE_W-1:0]  slot_limit = USE_RESET;

   // expectation that travels with a table row
   bit         fixed_typed = 1'b0;
   result_type fixed_want  = '0;

   result_type    blend_q [$];
   int            mismatch_count = 0;
   idle_mode_type idle_mode      = IDLE_NONE;
   int            hold_pending   = 0;
   int            hold_served    = 0;

   // slot 3 first in every packed group
   blend_row_type blend_tab [TAB_LEN] = '{
      // no valid slot: slot 0 takes the whole weight, bones cleared
      '{'{4'b0000, {8'd4, 8'd3, 8'd2, 8'd1}, {32'd0, 32'd0, 32'd0, 32'd0}}, 1'b1,
        '{{8'd0, 8'd0, 8'd0, 8'd0}, {16'd0, 16'd0, 16'd0, 16'd32768}}},
      '{'{4'b1111, {8'd85, 8'd170, 8'd0, 8'd255}, {32'd0, 32'd0, 32'd0, 32'd0}}, 1'b1,
        '{{8'd85, 8'd170, 8'd0, 8'd255}, {16'd8192, 16'd8192, 16'd8192, 16'd8192}}},
      // all at the floor weight
      '{'{4'b1111, {8'hFF, 8'h00, 8'h55, 8'hAA},
          {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}}, 1'b1,
        '{{8'hFF, 8'h00, 8'h55, 8'hAA}, {16'd8192, 16'd8192, 16'd8192, 16'd8192}}},
      '{'{4'b0001, {8'd9, 8'd9, 8'd9, 8'd7}, {32'd0, 32'd0, 32'd0, 32'd0}}, 1'b1,
        '{{8'd0, 8'd0, 8'd0, 8'd7}, {16'd0, 16'd0, 16'd0, 16'd32768}}},
      '{'{4'b0011, {8'd0, 8'd0, 8'd2, 8'd1}, {32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0}}, 1'b1,
        '{{8'd0, 8'd0, 8'd2, 8'd1}, {16'd0, 16'd0, 16'd32, 16'd32735}}},
      // invalid slot ahead of the only valid one: raw weight stays put
      '{'{4'b0010, {8'd3, 8'd2, 8'd66, 8'd5}, {32'd0, 32'd0, 32'd0, 32'd0}}, 1'b1,
        '{{8'd0, 8'd0, 8'd66, 8'd0}, {16'd0, 16'd0, 16'd32768, 16'd0}}},
      '{'{4'b0011, {8'd1, 8'd2, 8'd3, 8'd4}, {32'd0, 32'd0, 32'd65536, 32'd0}}, 1'b0, '0},
      '{'{4'b0011, {8'd1, 8'd2, 8'd3, 8'd4}, {32'd0, 32'd0, 32'd65537, 32'd65535}}, 1'b0, '0},
      '{'{4'b0001, {8'd1, 8'd2, 8'd3, 8'd4}, {32'd0, 32'd0, 32'd0, 32'd32768}}, 1'b0, '0},
      '{'{4'b0111, {8'd10, 8'd20, 8'd30, 8'd40},
          {32'd40000, 32'd20000, 32'd100, 32'd5}}, 1'b0, '0},
      '{'{4'b0101, {8'd11, 8'd22, 8'd33, 8'd44},
          {32'd1000, 32'd30000, 32'd7, 32'd50000}}, 1'b0, '0},
      '{'{4'b1000, {8'd128, 8'd1, 8'd2, 8'd3}, {32'd12345, 32'd0, 32'd0, 32'd0}}, 1'b0, '0},
      '{'{4'b1011, {8'd200, 8'd100, 8'd50, 8'd25},
          {32'd600, 32'd0, 32'd64000, 32'd9}}, 1'b0, '0},
      '{'{4'b1111, {8'd12, 8'd34, 8'd56, 8'd78},
          {32'd30000, 32'd65535, 32'd1, 32'd60000}}, 1'b0, '0},
      '{'{4'b1110, {8'd90, 8'd80, 8'd70, 8'd60},
          {32'd100, 32'd200, 32'd300, 32'd0}}, 1'b0, '0},
      '{'{4'b1111, {8'd1, 8'd2, 8'd4, 8'd8},
          {32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_FFFF}}, 1'b0, '0},
      // around the floor: raw 33, 34 and 35
      '{'{4'b0111, {8'd5, 8'd6, 8'd7, 8'd8},
          {32'd0, 32'd65466, 32'd65468, 32'd65470}}, 1'b0, '0}
   };

   skin_weight_normalizer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_valid_0    (drv.valid[0]),
      .req_bone_0     (drv.bone[0]),
      .req_dist_sq_0  (drv.dist_sq[0]),
      .req_valid_1    (drv.valid[1]),
      .req_bone_1     (drv.bone[1]),
      .req_dist_sq_1  (drv.dist_sq[1]),
      .req_valid_2    (drv.valid[2]),
      .req_bone_2     (drv.bone[2]),
      .req_dist_sq_2  (drv.dist_sq[2]),
      .req_valid_3    (drv.valid[3]),
      .req_bone_3     (drv.bone[3]),
      .req_dist_sq_3  (drv.dist_sq[3]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bone_0 (rsp_out_bone_0),
      .rsp_weight_0   (rsp_weight_0),
      .rsp_out_bone_1 (rsp_out_bone_1),
      .rsp_weight_1   (rsp_weight_1),
      .rsp_out_bone_2 (rsp_out_bone_2),
      .rsp_weight_2   (rsp_weight_2),
      .rsp_out_bone_3 (rsp_out_bone_3),
      .rsp_weight_3   (rsp_weight_3),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // blend indices and normalized weights under the current register values
   function automatic result_type predict_blend(vertex_type v);
      result_type  r;
      logic [63:0] rsq;
      logic [63:0] sum;
      logic [63:0] w [FIELD_SLOTS];
      int          in_use;
      int          count;
      rsq    = 64'(radius_q8) * 64'(radius_q8);
      in_use = (slot_limit > 3'd4) ? 4 : int'(slot_limit);
      sum    = 0;
      count  = 0;
      for (int k = 0; k < FIELD_SLOTS; k++) begin
         r.bone[k] = '0;
         w[k]      = 0;
         if (k < in_use && v.valid[k]) begin
            r.bone[k] = v.bone[k];
            if (rsq != 0 && 64'(v.dist_sq[k]) < rsq)
               w[k] = ((rsq - 64'(v.dist_sq[k])) << 15) / rsq;
            if (w[k] <= 64'(FLOOR_Q15))
               w[k] = 64'(FLOOR_Q15);
            sum   += w[k];
            count += 1;
         end
      end
      if (count == 0) begin
         w[0] = 64'(ONE_Q15);
      end else begin
         // only the first count positions are scaled, valid or not
         for (int k = 0; k < count; k++)
            w[k] = (w[k] * 64'(ONE_Q15)) / sum;
      end
      for (int k = 0; k < FIELD_SLOTS; k++)
         r.weight[k] = w[k][WEIGHT_W-1:0];
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] random_dist(logic [63:0] rsq);
      logic [DIST_W-1:0] d;
      case ($urandom_range(9))
         0: d = $urandom;
         1: begin
            case ($urandom_range(4))
               0: d = '0;
               1: d = DIST_W'(rsq - 1);
               2: d = DIST_W'(rsq);
               3: d = DIST_W'(rsq + 1);
               default: d = '1;
            endcase
         end
         default: d = (rsq != 0) ? DIST_W'(64'($urandom) % rsq) : DIST_W'($urandom);
      endcase
      return d;
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type  v;
      logic [63:0] rsq;
      int          n;
      rsq = 64'(radius_q8) * 64'(radius_q8);
      // mostly valid slots packed at the front, the rest arbitrary patterns
      if ($urandom_range(99) < 75) begin
         n       = $urandom_range(FIELD_SLOTS);
         v.valid = FIELD_SLOTS'((1 << n) - 1);
      end else begin
         v.valid = FIELD_SLOTS'($urandom);
      end
      for (int k = 0; k < FIELD_SLOTS; k++) begin
         v.bone[k]    = BONE_W'($urandom);
         v.dist_sq[k] = random_dist(rsq);
      end
      return v;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SEND: return 46;
         IDLE_BOTH: return 24;
         default:   return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECV: return 46;
         IDLE_BOTH: return 24;
         default:   return 0;
      endcase
   endfunction

   // entered and left at a falling edge; valid stays high on exit
   task automatic send_vertex(vertex_type v, bit typed, result_type want);
      int pct;
      pct = sender_idle_pct();
      if (pct > 0 && $urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < pct);
      end
      req_valid   <= 1'b1;
      drv         <= v;
      fixed_typed <= typed;
      fixed_want  <= want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle();
      wait (blend_q.size() == 0);
      repeat (SETTLE_GAP) @(negedge clock);
   endtask

   task automatic csr_access(input reg_index_type idx, input bit wr,
                             input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_W'(4 * int'(idx));
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_register(reg_index_type idx, logic [DATA_W-1:0] want);
      logic [DATA_W-1:0] rd;
      csr_access(idx, 1'b0, '0, rd);
      if (rd !== want) begin
         $error("%s readback: expected %0d, got %0d", idx.name(), want, rd);
         mismatch_count++;
      end
   endtask

   task automatic set_register(reg_index_type idx, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] rd;
      mask = (idx == REG_MAX_DISTANCE) ? DATA_W'(16'hFFFF) : DATA_W'(3'h7);
      // junk above the register width must be dropped
      csr_access(idx, 1'b1, (value & mask) | ($urandom & ~mask), rd);
      if (idx == REG_MAX_DISTANCE)
         radius_q8 = value[MAXD_W-1:0];
      else
         slot_limit = value[USE_W-1:0];
      check_register(idx, value & mask);
   endtask

   task automatic run_phase(int radius, int slots, idle_mode_type mode, int items,
                            int hold_at, int pause_at);
      settle();
      set_register(REG_MAX_DISTANCE, DATA_W'(radius));
      set_register(REG_SLOTS_IN_USE, DATA_W'(slots));
      idle_mode = mode;
      for (int i = 0; i < items; i++) begin
         if (i == hold_at)
            hold_pending++;
         if (i == pause_at) begin
            req_valid <= 1'b0;
            wait (blend_q.size() == 0);
            @(negedge clock);
         end
         send_vertex(random_vertex(), 1'b0, '0);
      end
      req_valid <= 1'b0;
   endtask

   // input beats: store the expectation at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         blend_q.push_back(fixed_typed ? fixed_want : predict_blend(drv));
   end

   // result beats
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.bone   = {rsp_out_bone_3, rsp_out_bone_2, rsp_out_bone_1, rsp_out_bone_0};
         got.weight = {rsp_weight_3, rsp_weight_2, rsp_weight_1, rsp_weight_0};
         if (blend_q.size() == 0) begin
            $error("result beat with no vertex outstanding");
            mismatch_count++;
         end else begin
            want = blend_q.pop_front();
            for (int k = 0; k < FIELD_SLOTS; k++) begin
               if (got.bone[k] !== want.bone[k]) begin
                  $error("out_bone_%0d: expected %0d, got %0d", k, want.bone[k], got.bone[k]);
                  mismatch_count++;
               end
               if (got.weight[k] !== want.weight[k]) begin
                  $error("weight_%0d: expected %0d, got %0d", k, want.weight[k],
                         got.weight[k]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int left;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_pending != hold_served) begin
            left        = HOLD_CYCLES;
            hold_served = hold_pending;
         end
         if (left > 0) begin
            left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct());
         end
      end
   end

   initial begin
      #400000;
      $display("** skin_weight_normalizer: FAILED **");
      $finish;
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      check_register(REG_MAX_DISTANCE, DATA_W'(MAXD_RESET));
      check_register(REG_SLOTS_IN_USE, DATA_W'(USE_RESET));

      idle_mode = IDLE_NONE;
      for (int i = 0; i < TAB_LEN; i++)
         send_vertex(blend_tab[i].vtx, blend_tab[i].typed, blend_tab[i].want);
      req_valid <= 1'b0;

      //        radius                 slots  idling     items hold  pause
      run_phase(256,                   4,     IDLE_NONE, 300,  -1,   -1);
      run_phase(65535,                 4,     IDLE_SEND, 250,  -1,   -1);
      run_phase(0,                     3,     IDLE_RECV, 150,  -1,   -1);
      run_phase(1,                     1,     IDLE_BOTH, 150,  -1,   -1);
      run_phase($urandom_range(65535), 2,     IDLE_BOTH, 250,  20,   -1);
      run_phase(255,                   0,     IDLE_NONE, 100,  -1,   -1);
      run_phase(300,                   7,     IDLE_SEND, 200,  -1,   -1);
      run_phase($urandom_range(65535), 4,     IDLE_RECV, 300,  -1,   150);

      wait (blend_q.size() == 0);
      repeat (TAIL_GAP) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** skin_weight_normalizer: PASSED **");
      end else begin
         $display("** skin_weight_normalizer: FAILED **");
      end
      $finish;
   end

endmodule
